@@ rtl/format_string_formatter_macros.svh @@
// Assertion macros shared by the format string formatter RTL.
`ifndef FORMAT_STRING_FORMATTER_MACROS_SVH
`define FORMAT_STRING_FORMATTER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define FSF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fsf: same-cycle check failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define FSF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fsf: next-cycle check failed");
`else
`define FSF_ASSERT_IMPLY(label, ante, cons)
`define FSF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/fsf_pkg.sv @@
// Types, character codes and helpers shared by the format string formatter.
package fsf_pkg;

   localparam int ARG_W    = 32;
   localparam int CHAR_W   = 7;
   localparam int WIDTH_W  = 6;
   localparam int COUNT_W  = 16;
   localparam int QDEPTH   = 4;

   // Format characters
   localparam logic [CHAR_W-1:0] CH_NUL     = 7'h00;
   localparam logic [CHAR_W-1:0] CH_PERCENT = 7'h25;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 7'h39;
   localparam logic [CHAR_W-1:0] CH_LC_D    = 7'h64;
   localparam logic [CHAR_W-1:0] CH_LC_U    = 7'h75;
   localparam logic [CHAR_W-1:0] CH_LC_B    = 7'h62;
   localparam logic [CHAR_W-1:0] CH_LC_O    = 7'h6F;
   localparam logic [CHAR_W-1:0] CH_LC_X    = 7'h78;
   localparam logic [CHAR_W-1:0] CH_UC_X    = 7'h58;
   localparam logic [CHAR_W-1:0] CH_LC_C    = 7'h63;

   // Emitted characters
   localparam logic [7:0] OUT_MINUS = 8'h2D;
   localparam logic [7:0] OUT_ZERO  = 8'h30;
   localparam logic [7:0] OUT_SPACE = 8'h20;
   localparam logic [7:0] OUT_HASH  = 8'h23;
   localparam logic [7:0] OUT_LC_A  = 8'h61;
   localparam logic [7:0] OUT_UC_A  = 8'h41;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_PCT  = 2'd1,
      MODE_WAIT = 2'd2,
      MODE_ERR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CONV_NONE = 3'd0,
      CONV_D    = 3'd1,
      CONV_U    = 3'd2,
      CONV_B    = 3'd3,
      CONV_O    = 3'd4,
      CONV_XL   = 3'd5,
      CONV_XU   = 3'd6,
      CONV_C    = 3'd7
   } conv_type;

   typedef enum logic [1:0] {
      OP_CHAR = 2'd0,
      OP_CONV = 2'd1,
      OP_END  = 2'd2,
      OP_ERR  = 2'd3
   } cmd_op_type;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_DABBLE,
      B_SKIP,
      B_ZSIGN,
      B_ZPAD,
      B_SPAD,
      B_SIGN,
      B_DIGITS,
      B_TPAD,
      B_HASH
   } back_state_type;

   // One classified command from the parser to the emitter
   typedef struct packed {
      cmd_op_type           op;
      logic [CHAR_W-1:0]    ch;
      conv_type             conv;
      logic [WIDTH_W-1:0]   width;
      logic                 zero_fill;
      logic                 pad_before;
      logic [ARG_W-1:0]     arg;
   } cmd_type;

   // Map a conversion letter to its code
   function automatic conv_type conv_code(input logic [CHAR_W-1:0] ch);
      conv_type code;
      unique case (ch)
         CH_LC_D: code = CONV_D;
         CH_LC_U: code = CONV_U;
         CH_LC_B: code = CONV_B;
         CH_LC_O: code = CONV_O;
         CH_LC_X: code = CONV_XL;
         CH_UC_X: code = CONV_XU;
         CH_LC_C: code = CONV_C;
         default: code = CONV_NONE;
      endcase
      return code;
   endfunction

   // ASCII for one digit, "0123456789abcdef" or its upper case form
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = OUT_ZERO + 8'(d);
      end else if (upper) begin
         c = OUT_UC_A + 8'(d - 4'd10);
      end else begin
         c = OUT_LC_A + 8'(d - 4'd10);
      end
      return c;
   endfunction

endpackage

@@ rtl/fsf_front.sv @@
// Format parser: accepts beats, tracks the specification, queues commands.
module fsf_front #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_func,
   input  logic [fsf_pkg::CHAR_W-1:0]   in_char,
   input  logic [fsf_pkg::ARG_W-1:0]    in_arg,
   input  logic                         q_full,
   output logic                         push,
   output fsf_pkg::cmd_type             push_cmd
);

   fsf_pkg::mode_type                mode_ff, mode_in;
   logic [fsf_pkg::WIDTH_W-1:0]      fw_ff, fw_in;
   logic                             zf_ff, zf_in;
   logic                             pb_ff, pb_in;
   fsf_pkg::conv_type                conv_ff, conv_in;

   logic                             accept;
   logic                             is_digit;
   fsf_pkg::conv_type                code;
   logic [8:0]                       width_next;

   assign in_ready   = !q_full;
   assign accept     = in_valid && in_ready;
   assign is_digit   = (in_char >= fsf_pkg::CH_ZERO) && (in_char <= fsf_pkg::CH_NINE);
   assign code       = fsf_pkg::conv_code(in_char);
   assign width_next = 9'(fw_ff) * 9'd10 + 9'(in_char[3:0]);

   // Next parse mode
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (in_func) begin
            if (mode_ff == fsf_pkg::MODE_WAIT) mode_in = fsf_pkg::MODE_TEXT;
         end else if (in_char == fsf_pkg::CH_NUL) begin
            mode_in = fsf_pkg::MODE_TEXT;
         end else begin
            unique case (mode_ff)
               fsf_pkg::MODE_TEXT: begin
                  if (in_char == fsf_pkg::CH_PERCENT) mode_in = fsf_pkg::MODE_PCT;
               end
               fsf_pkg::MODE_PCT: begin
                  if (in_char == fsf_pkg::CH_PERCENT) begin
                     mode_in = fsf_pkg::MODE_TEXT;
                  end else if (in_char == fsf_pkg::CH_MINUS || is_digit) begin
                     mode_in = fsf_pkg::MODE_PCT;
                  end else if (code != fsf_pkg::CONV_NONE) begin
                     mode_in = fsf_pkg::MODE_WAIT;
                  end else begin
                     mode_in = fsf_pkg::MODE_ERR;
                  end
               end
               fsf_pkg::MODE_WAIT: mode_in = fsf_pkg::MODE_ERR;
               fsf_pkg::MODE_ERR:  mode_in = fsf_pkg::MODE_ERR;
               default:            mode_in = fsf_pkg::MODE_TEXT;
            endcase
         end
      end
   end

   // Command toward the emitter
   always_comb begin
      push                = 1'b0;
      push_cmd.op         = fsf_pkg::OP_CHAR;
      push_cmd.ch         = in_char;
      push_cmd.conv       = conv_ff;
      push_cmd.width      = fw_ff;
      push_cmd.zero_fill  = zf_ff;
      push_cmd.pad_before = pb_ff;
      push_cmd.arg        = in_arg;
      if (accept) begin
         if (in_func) begin
            if (mode_ff == fsf_pkg::MODE_WAIT) begin
               push        = 1'b1;
               push_cmd.op = fsf_pkg::OP_CONV;
            end
         end else if (in_char == fsf_pkg::CH_NUL) begin
            push        = 1'b1;
            push_cmd.op = fsf_pkg::OP_END;
         end else begin
            unique case (mode_ff)
               fsf_pkg::MODE_TEXT: begin
                  push = (in_char != fsf_pkg::CH_PERCENT);
               end
               fsf_pkg::MODE_PCT: begin
                  if (in_char == fsf_pkg::CH_PERCENT) begin
                     push = 1'b1;
                  end else if (!(in_char == fsf_pkg::CH_MINUS || is_digit)
                               && code == fsf_pkg::CONV_NONE) begin
                     push        = 1'b1;
                     push_cmd.op = fsf_pkg::OP_ERR;
                  end
               end
               fsf_pkg::MODE_WAIT: begin
                  push        = 1'b1;
                  push_cmd.op = fsf_pkg::OP_ERR;
               end
               fsf_pkg::MODE_ERR: push = 1'b0;
               default:           push = 1'b0;
            endcase
         end
      end
   end

   // Specification flags and width
   always_comb begin
      fw_in   = fw_ff;
      zf_in   = zf_ff;
      pb_in   = pb_ff;
      conv_in = conv_ff;
      if (accept) begin
         if ((in_func && mode_ff == fsf_pkg::MODE_WAIT)
             || (!in_func && in_char == fsf_pkg::CH_NUL)
             || (!in_func && mode_ff == fsf_pkg::MODE_WAIT)
             || (!in_func && mode_ff == fsf_pkg::MODE_PCT
                 && in_char == fsf_pkg::CH_PERCENT)) begin
            fw_in   = '0;
            zf_in   = 1'b0;
            pb_in   = 1'b0;
            conv_in = fsf_pkg::CONV_NONE;
         end else if (!in_func && mode_ff == fsf_pkg::MODE_PCT) begin
            if (in_char == fsf_pkg::CH_MINUS) begin
               pb_in = 1'b1;
            end else if (is_digit) begin
               if (in_char == fsf_pkg::CH_ZERO && fw_ff == '0) zf_in = 1'b1;
               // saturate the width at the configured maximum
               if (width_next > 9'(MAX_WIDTH)) begin
                  fw_in = fsf_pkg::WIDTH_W'(MAX_WIDTH);
               end else begin
                  fw_in = width_next[fsf_pkg::WIDTH_W-1:0];
               end
            end else if (code != fsf_pkg::CONV_NONE) begin
               conv_in = code;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= fsf_pkg::MODE_TEXT;
         fw_ff   <= '0;
         zf_ff   <= 1'b0;
         pb_ff   <= 1'b0;
         conv_ff <= fsf_pkg::CONV_NONE;
      end else begin
         mode_ff <= mode_in;
         fw_ff   <= fw_in;
         zf_ff   <= zf_in;
         pb_ff   <= pb_in;
         conv_ff <= conv_in;
      end
   end

endmodule

@@ rtl/fsf_queue.sv @@
// Short command queue between the parser and the emitter.
module fsf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fsf_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output fsf_pkg::cmd_type  head,
   output logic              empty
);

   localparam int PTR_W = $clog2(fsf_pkg::QDEPTH);
   localparam int CNT_W = $clog2(fsf_pkg::QDEPTH + 1);

   fsf_pkg::cmd_type     entry_ff [fsf_pkg::QDEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(fsf_pkg::QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and fill level
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(fsf_pkg::QDEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(fsf_pkg::QDEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + CNT_W'(1);
      if (!do_push && do_pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_cmd;
   end

endmodule

@@ rtl/fsf_back.sv @@
// Emitter: carries out queued commands, at most one result beat per cycle while the response side is ready.
module fsf_back #(
   parameter int ARG_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fsf_pkg::cmd_type              q_cmd,
   input  logic                          q_empty,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_take,
   output fsf_pkg::kind_type             out_kind,
   output logic [7:0]                    out_char,
   output logic [fsf_pkg::COUNT_W-1:0]   out_total,
   output logic                          out_last
);

   localparam int DIG_N = ARG_BITS;
   localparam int DEC_N = (ARG_BITS * 30103) / 100000 + 1;
   localparam int OCT_N = (ARG_BITS + 2) / 3;
   localparam int HEX_N = (ARG_BITS + 3) / 4;
   localparam int IDX_W = $clog2(DIG_N);
   localparam int ND_W  = IDX_W + 1;
   localparam int CNT_W = $clog2(ARG_BITS + 1);
   localparam logic [IDX_W-1:0] DEC_TOP = IDX_W'(DEC_N - 1);
   localparam logic [IDX_W-1:0] BIN_TOP = IDX_W'(DIG_N - 1);
   localparam logic [IDX_W-1:0] OCT_TOP = IDX_W'(OCT_N - 1);
   localparam logic [IDX_W-1:0] HEX_TOP = IDX_W'(HEX_N - 1);

   fsf_pkg::back_state_type   state_ff, state_in;
   logic [3:0]                dig_ff [DIG_N];
   logic [3:0]                dig_in [DIG_N];
   logic [ARG_BITS-1:0]       bin_ff, bin_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [ND_W-1:0]           nd_ff, nd_in;
   logic signed [6:0]         w_ff, w_in;
   logic                      neg_ff, neg_in;
   logic                      zf_ff, zf_in;
   logic                      pb_ff, pb_in;
   logic                      isd_ff, isd_in;
   logic                      upper_ff, upper_in;

   logic                      valid_ff;
   fsf_pkg::kind_type         kind_ff;
   logic [7:0]                char_ff;
   logic [fsf_pkg::COUNT_W-1:0] total_ff;
   logic                      last_ff;
   logic [fsf_pkg::COUNT_W-1:0] count_ff;

   logic                      out_ready;
   logic                      res_valid;
   fsf_pkg::kind_type         res_kind;
   logic [7:0]                res_char;
   logic                      res_last;

   logic [ARG_BITS-1:0]       arg_a;
   logic                      ld_neg;
   logic [ARG_BITS-1:0]       mag;
   logic                      load;
   wire  [3:0]                ld_bin [DIG_N];
   wire  [3:0]                ld_oct [DIG_N];
   wire  [3:0]                ld_hex [DIG_N];
   wire  [3:0]                adj    [DEC_N];
   wire  [3:0]                dab    [DIG_N];
   logic [3:0]                cur_dig;
   logic                      skip_more;
   logic [ND_W-1:0]           nd_cur;
   logic signed [7:0]         w_ext, wm1_ext, nd_ext;
   logic                      w_gt, w1_gt;
   logic                      trail_pad;

   assign out_ready = !valid_ff || out_take;
   assign arg_a     = q_cmd.arg[ARG_BITS-1:0];
   assign ld_neg    = (q_cmd.conv == fsf_pkg::CONV_D) && arg_a[ARG_BITS-1];
   assign mag       = ld_neg ? (~arg_a + ARG_BITS'(1)) : arg_a;
   assign pop       = (state_ff == fsf_pkg::B_IDLE) && !q_empty && out_ready;
   assign load      = pop && (q_cmd.op == fsf_pkg::OP_CONV) && (q_cmd.conv != fsf_pkg::CONV_C);

   // Split the argument into binary, octal and hex digits
   for (genvar gi = 0; gi < DIG_N; gi++) begin : g_load
      assign ld_bin[gi] = {3'b000, arg_a[gi]};
      for (genvar gb = 0; gb < 4; gb++) begin : g_bit
         if (gb < 3 && 3 * gi + gb < ARG_BITS) begin : g_oct_on
            assign ld_oct[gi][gb] = arg_a[3 * gi + gb];
         end else begin : g_oct_off
            assign ld_oct[gi][gb] = 1'b0;
         end
         if (4 * gi + gb < ARG_BITS) begin : g_hex_on
            assign ld_hex[gi][gb] = arg_a[4 * gi + gb];
         end else begin : g_hex_off
            assign ld_hex[gi][gb] = 1'b0;
         end
      end
   end

   // One double-dabble step: add three to digits above four, then shift in
   for (genvar gj = 0; gj < DIG_N; gj++) begin : g_dab
      if (gj < DEC_N) begin : g_dec
         assign adj[gj] = (dig_ff[gj] >= 4'd5) ? dig_ff[gj] + 4'd3 : dig_ff[gj];
         if (gj == 0) begin : g_lsd
            assign dab[gj] = {adj[gj][2:0], bin_ff[ARG_BITS-1]};
         end else begin : g_upper
            assign dab[gj] = {adj[gj][2:0], adj[gj-1][3]};
         end
      end else begin : g_unused
         assign dab[gj] = 4'd0;
      end
   end

   // Digit pointer and width comparisons
   assign cur_dig   = dig_ff[idx_ff];
   assign skip_more = (cur_dig == 4'd0) && (idx_ff != '0);
   assign nd_cur    = (state_ff == fsf_pkg::B_SKIP) ? ND_W'(idx_ff) + ND_W'(1) : nd_ff;
   assign w_ext     = {w_ff[6], w_ff};
   assign wm1_ext   = w_ext - 8'sd1;
   assign nd_ext    = 8'(nd_cur);
   assign w_gt      = w_ext > nd_ext;
   assign w1_gt     = wm1_ext > nd_ext;
   assign trail_pad = isd_ff && !pb_ff && w_gt;

   // Next state of the emit sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsf_pkg::B_IDLE: begin
            if (load) begin
               if (q_cmd.conv == fsf_pkg::CONV_D || q_cmd.conv == fsf_pkg::CONV_U) begin
                  state_in = fsf_pkg::B_DABBLE;
               end else begin
                  state_in = fsf_pkg::B_SKIP;
               end
            end
         end
         fsf_pkg::B_DABBLE: begin
            if (cnt_ff == CNT_W'(1)) state_in = fsf_pkg::B_SKIP;
         end
         fsf_pkg::B_SKIP: begin
            if (!skip_more) begin
               if (!isd_ff)                 state_in = fsf_pkg::B_DIGITS;
               else if (zf_ff && neg_ff)    state_in = fsf_pkg::B_ZSIGN;
               else if (zf_ff && w_gt)      state_in = fsf_pkg::B_ZPAD;
               else if (pb_ff && w_gt)      state_in = fsf_pkg::B_SPAD;
               else if (neg_ff)             state_in = fsf_pkg::B_SIGN;
               else                         state_in = fsf_pkg::B_DIGITS;
            end
         end
         fsf_pkg::B_ZSIGN: begin
            if (out_ready) state_in = w1_gt ? fsf_pkg::B_ZPAD : fsf_pkg::B_DIGITS;
         end
         fsf_pkg::B_ZPAD: begin
            if (out_ready && !w1_gt) state_in = fsf_pkg::B_DIGITS;
         end
         fsf_pkg::B_SPAD: begin
            if (out_ready && !w1_gt) state_in = neg_ff ? fsf_pkg::B_SIGN : fsf_pkg::B_DIGITS;
         end
         fsf_pkg::B_SIGN: begin
            if (out_ready) state_in = fsf_pkg::B_DIGITS;
         end
         fsf_pkg::B_DIGITS: begin
            if (out_ready && idx_ff == '0) begin
               state_in = trail_pad ? fsf_pkg::B_TPAD : fsf_pkg::B_IDLE;
            end
         end
         fsf_pkg::B_TPAD: begin
            if (out_ready && !w1_gt) state_in = fsf_pkg::B_HASH;
         end
         fsf_pkg::B_HASH: begin
            if (out_ready) state_in = fsf_pkg::B_IDLE;
         end
         default: state_in = fsf_pkg::B_IDLE;
      endcase
   end

   // Result beat produced by the current state
   always_comb begin
      res_valid = 1'b0;
      res_kind  = fsf_pkg::KIND_CHAR;
      res_char  = 8'd0;
      res_last  = 1'b0;
      unique case (state_ff)
         fsf_pkg::B_IDLE: begin
            if (pop) begin
               unique case (q_cmd.op)
                  fsf_pkg::OP_CHAR: begin
                     res_valid = 1'b1;
                     res_char  = {1'b0, q_cmd.ch};
                     res_last  = 1'b1;
                  end
                  fsf_pkg::OP_END: begin
                     res_valid = 1'b1;
                     res_kind  = fsf_pkg::KIND_END;
                     res_last  = 1'b1;
                  end
                  fsf_pkg::OP_ERR: begin
                     res_valid = 1'b1;
                     res_kind  = fsf_pkg::KIND_ERR;
                     res_last  = 1'b1;
                  end
                  fsf_pkg::OP_CONV: begin
                     if (q_cmd.conv == fsf_pkg::CONV_C) begin
                        res_valid = 1'b1;
                        res_char  = arg_a[7:0];
                        res_last  = 1'b1;
                     end
                  end
                  default: res_valid = 1'b0;
               endcase
            end
         end
         fsf_pkg::B_ZSIGN, fsf_pkg::B_SIGN: begin
            res_valid = 1'b1;
            res_char  = fsf_pkg::OUT_MINUS;
         end
         fsf_pkg::B_ZPAD: begin
            res_valid = 1'b1;
            res_char  = fsf_pkg::OUT_ZERO;
         end
         fsf_pkg::B_SPAD, fsf_pkg::B_TPAD: begin
            res_valid = 1'b1;
            res_char  = fsf_pkg::OUT_SPACE;
         end
         fsf_pkg::B_DIGITS: begin
            res_valid = 1'b1;
            res_char  = fsf_pkg::digit_char(cur_dig, upper_ff);
            res_last  = (idx_ff == '0) && !trail_pad;
         end
         fsf_pkg::B_HASH: begin
            res_valid = 1'b1;
            res_char  = fsf_pkg::OUT_HASH;
            res_last  = 1'b1;
         end
         default: res_valid = 1'b0;
      endcase
   end

   // Datapath next values
   always_comb begin
      dig_in   = dig_ff;
      bin_in   = bin_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      nd_in    = nd_ff;
      w_in     = w_ff;
      neg_in   = neg_ff;
      zf_in    = zf_ff;
      pb_in    = pb_ff;
      isd_in   = isd_ff;
      upper_in = upper_ff;
      case (state_ff)
         fsf_pkg::B_IDLE: begin
            if (load) begin
               isd_in   = (q_cmd.conv == fsf_pkg::CONV_D);
               upper_in = (q_cmd.conv == fsf_pkg::CONV_XU);
               zf_in    = q_cmd.zero_fill;
               pb_in    = q_cmd.pad_before;
               neg_in   = ld_neg;
               w_in     = signed'({1'b0, q_cmd.width});
               case (q_cmd.conv)
                  fsf_pkg::CONV_D, fsf_pkg::CONV_U: begin
                     for (int i = 0; i < DIG_N; i++) dig_in[i] = 4'd0;
                     bin_in = mag;
                     cnt_in = CNT_W'(ARG_BITS);
                     idx_in = DEC_TOP;
                  end
                  fsf_pkg::CONV_B: begin
                     dig_in = ld_bin;
                     idx_in = BIN_TOP;
                  end
                  fsf_pkg::CONV_O: begin
                     dig_in = ld_oct;
                     idx_in = OCT_TOP;
                  end
                  fsf_pkg::CONV_XL, fsf_pkg::CONV_XU: begin
                     dig_in = ld_hex;
                     idx_in = HEX_TOP;
                  end
                  default: idx_in = idx_ff;
               endcase
            end
         end
         fsf_pkg::B_DABBLE: begin
            dig_in = dab;
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         fsf_pkg::B_SKIP: begin
            // drop leading zero digits, then fix the digit count
            if (skip_more) idx_in = idx_ff - IDX_W'(1);
            else           nd_in  = nd_cur;
         end
         fsf_pkg::B_ZSIGN: begin
            if (out_ready) begin
               w_in   = w_ff - 7'sd1;
               neg_in = 1'b0;
            end
         end
         fsf_pkg::B_ZPAD, fsf_pkg::B_SPAD, fsf_pkg::B_TPAD: begin
            if (out_ready) w_in = w_ff - 7'sd1;
         end
         fsf_pkg::B_DIGITS: begin
            if (out_ready && idx_ff != '0) idx_in = idx_ff - IDX_W'(1);
         end
         default: w_in = w_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsf_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff   <= dig_in;
      bin_ff   <= bin_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      nd_ff    <= nd_in;
      w_ff     <= w_in;
      neg_ff   <= neg_in;
      zf_ff    <= zf_in;
      pb_ff    <= pb_in;
      isd_ff   <= isd_in;
      upper_ff <= upper_in;
   end

   // Output register and saturating character count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (out_ready) valid_ff <= res_valid;
         if (res_valid && out_ready) begin
            if (res_kind == fsf_pkg::KIND_END) begin
               count_ff <= '0;
            end else if (res_kind == fsf_pkg::KIND_CHAR && count_ff != '1) begin
               count_ff <= count_ff + fsf_pkg::COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && out_ready) begin
         kind_ff  <= res_kind;
         char_ff  <= res_char;
         total_ff <= (res_kind == fsf_pkg::KIND_END) ? count_ff : '0;
         last_ff  <= res_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_char  = char_ff;
   assign out_total = total_ff;
   assign out_last  = last_ff;

endmodule

@@ rtl/format_string_formatter.sv @@
// Top level of the printf-style integer format string formatter.
//
// Format characters and argument words arrive as request beats; every
// character of output leaves as one response beat, and the final beat caused
// by a request carries tlast. The parser takes one request beat per cycle
// while its four-entry command queue has room. The emitter sends plain
// characters, '%%', errors, %c and the terminator straight from the queue.
// Every other conversion first loads its argument; d and u then run a
// binary-to-decimal conversion over every argument bit. Leading zero digits
// are dropped one at a time before the digit count is settled, and each
// emitted character then leaves in turn. The emitter's single sequencer
// does this work; response backpressure stalls it without losing data.
`include "format_string_formatter_macros.svh"

module format_string_formatter #(
   parameter int MAX_WIDTH = 32,
   parameter int ARG_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // fmt_char [6:0], arg_value [38:7], zero [39]
   input  logic [0:0]  req_tuser,   // func [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_char [7:0], total_chars [23:8]
   output logic [1:0]  rsp_tuser,   // kind [1:0]
   output logic        rsp_tlast
);

   logic                          q_push;
   fsf_pkg::cmd_type              q_push_cmd;
   logic                          q_full;
   logic                          q_pop;
   fsf_pkg::cmd_type              q_head;
   logic                          q_empty;
   fsf_pkg::kind_type             out_kind;
   logic [7:0]                    out_char;
   logic [fsf_pkg::COUNT_W-1:0]   out_total;
   logic                          rsp_status;

   fsf_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_func  (req_tuser[0]),
      .in_char  (req_tdata[6:0]),
      .in_arg   (req_tdata[38:7]),
      .q_full   (q_full),
      .push     (q_push),
      .push_cmd (q_push_cmd)
   );

   fsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   fsf_back #(
      .ARG_BITS (ARG_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_cmd     (q_head),
      .q_empty   (q_empty),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_take  (rsp_tready),
      .out_kind  (out_kind),
      .out_char  (out_char),
      .out_total (out_total),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {out_total, out_char};
   assign rsp_tuser = out_kind;

   // Terminator or error beat on the response side
   assign rsp_status = (rsp_tuser == fsf_pkg::KIND_END) || (rsp_tuser == fsf_pkg::KIND_ERR);

   // Parser never pushes into a full queue
   `FSF_ASSERT_IMPLY(a_no_overflow, q_push, !q_full)
   // A push into an empty queue leaves a command for the emitter
   `FSF_ASSERT_NEXT(a_push_lands, q_push && q_empty, !q_empty)
   // Terminator and error beats stand alone and close their request
   `FSF_ASSERT_IMPLY(a_status_last, rsp_tvalid && rsp_status, rsp_tlast && rsp_tdata[7:0] == 8'd0)

endmodule

@@ tb/format_string_checker.sv @@
// Checker for the format string formatter: predicts output beats and compares them.
`timescale 1ns / 1ps

module format_string_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // fmt_char [6:0], arg_value [38:7], zero [39]
   input  logic [0:0]  req_tuser,   // func [0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // out_char [7:0], total_chars [23:8]
   input  logic [1:0]  rsp_tuser,   // kind [1:0]
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          beats_pending
);
   import fsf_pkg::*;

   localparam int WIDTH_CAP  = 32;

   typedef struct packed {
      kind_type     kind;
      logic [7:0]   out_char;
      logic [15:0]  total;
      logic         last;
   } out_beat_t;

   // Output beats still owed by the block, oldest first
   out_beat_t expected_beats[$];
   // Output beats caused by the request beat being predicted
   out_beat_t step_beats[$];

   // Parser state mirrored from the formatter
   mode_type    fmt_mode;
   logic [5:0]  spec_width;
   logic        spec_zero;
   logic        spec_left;
   conv_type    spec_conv;
   logic [15:0] emitted_count;
   logic [7:0]  digit_buf [0:31];

   function automatic void push_beat(kind_type k, logic [7:0] c, logic [15:0] t);
      out_beat_t b;
      b.kind     = k;
      b.out_char = c;
      b.total    = t;
      b.last     = 1'b0;
      step_beats.push_back(b);
   endfunction

   // Queue one character and bump the saturating count
   function automatic void emit_char(logic [7:0] c);
      push_beat(KIND_CHAR, c, '0);
      if (emitted_count != 16'hFFFF) begin
         emitted_count = emitted_count + 16'd1;
      end
   endfunction

   function automatic void clear_spec();
      spec_width = '0;
      spec_zero  = 1'b0;
      spec_left  = 1'b0;
      spec_conv  = CONV_NONE;
   endfunction

   function automatic void clear_all();
      fmt_mode      = MODE_TEXT;
      emitted_count = '0;
      clear_spec();
   endfunction

   // Fill digit_buf with the digits of v, most significant first; return the count
   function automatic int to_digits(logic [31:0] v, int unsigned radix, bit upper);
      string       tab;
      logic [31:0] rest;
      logic [7:0]  rev [0:31];
      int          n;
      int          i;
      tab  = upper ? "0123456789ABCDEF" : "0123456789abcdef";
      rest = v;
      n    = 0;
      do begin
         rev[n] = tab[int'(rest % radix)];
         rest   = rest / radix;
         n++;
      end while (rest != 0);
      for (i = 0; i < n; i++) begin
         digit_buf[i] = rev[n - 1 - i];
      end
      return n;
   endfunction

   // Expand the pending conversion for one argument word
   function automatic void convert_arg(logic [31:0] a);
      logic        neg;
      logic [31:0] mag;
      int          nd;
      int          w;
      int          i;
      int unsigned radix;
      bit          upper;
      if (spec_conv == CONV_D) begin
         neg = a[31];
         mag = neg ? (~a + 32'd1) : a;
         nd  = to_digits(mag, 10, 1'b0);
         w   = int'(spec_width);
         // zero fill puts the sign first and counts it against the width
         if (spec_zero) begin
            if (neg) begin
               emit_char(OUT_MINUS);
               w--;
               neg = 1'b0;
            end
            while (w > nd) begin
               emit_char(OUT_ZERO);
               w--;
            end
         end
         if (spec_left) begin
            while (w > nd) begin
               emit_char(OUT_SPACE);
               w--;
            end
         end
         if (neg) begin
            emit_char(OUT_MINUS);
         end
         for (i = 0; i < nd; i++) begin
            emit_char(digit_buf[i]);
         end
         // without '-' the pad trails and closes with a hash
         if (!spec_left && w > nd) begin
            while (w > nd) begin
               emit_char(OUT_SPACE);
               w--;
            end
            emit_char(OUT_HASH);
         end
      end else if (spec_conv == CONV_C) begin
         emit_char(a[7:0]);
      end else begin
         radix = 10;
         upper = 1'b0;
         case (spec_conv)
            CONV_B:  radix = 2;
            CONV_O:  radix = 8;
            CONV_XL: radix = 16;
            CONV_XU: begin
               radix = 16;
               upper = 1'b1;
            end
            default: ;
         endcase
         nd = to_digits(a, radix, upper);
         for (i = 0; i < nd; i++) begin
            emit_char(digit_buf[i]);
         end
      end
   endfunction

   // Advance the parser by one request beat and queue the beats it causes
   function automatic void predict_output_beats(logic func, logic [6:0] ch, logic [31:0] a);
      conv_type code;
      int       nw;
      step_beats.delete();
      if (func) begin
         if (fmt_mode == MODE_WAIT) begin
            convert_arg(a);
            clear_spec();
            fmt_mode = MODE_TEXT;
         end
      end else if (ch == CH_NUL) begin
         push_beat(KIND_END, '0, emitted_count);
         clear_all();
      end else begin
         case (fmt_mode)
            MODE_TEXT: begin
               if (ch == CH_PERCENT) fmt_mode = MODE_PCT;
               else emit_char({1'b0, ch});
            end
            MODE_PCT: begin
               if (ch == CH_PERCENT) begin
                  emit_char({1'b0, CH_PERCENT});
                  clear_spec();
                  fmt_mode = MODE_TEXT;
               end else if (ch == CH_MINUS) begin
                  spec_left = 1'b1;
               end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
                  // a leading zero digit turns on zero fill
                  if (ch == CH_ZERO && spec_width == '0) spec_zero = 1'b1;
                  nw = int'(spec_width) * 10 + int'(ch - CH_ZERO);
                  spec_width = (nw > WIDTH_CAP) ? 6'(WIDTH_CAP) : 6'(nw);
               end else begin
                  case (ch)
                     CH_LC_D: code = CONV_D;
                     CH_LC_U: code = CONV_U;
                     CH_LC_B: code = CONV_B;
                     CH_LC_O: code = CONV_O;
                     CH_LC_X: code = CONV_XL;
                     CH_UC_X: code = CONV_XU;
                     CH_LC_C: code = CONV_C;
                     default: code = CONV_NONE;
                  endcase
                  if (code != CONV_NONE) begin
                     spec_conv = code;
                     fmt_mode  = MODE_WAIT;
                  end else begin
                     push_beat(KIND_ERR, '0, '0);
                     fmt_mode = MODE_ERR;
                  end
               end
            end
            MODE_WAIT: begin
               // a character where an argument belongs drops the conversion
               push_beat(KIND_ERR, '0, '0);
               clear_spec();
               fmt_mode = MODE_ERR;
            end
            default: ;
         endcase
      end
      if (step_beats.size() > 0) begin
         step_beats[step_beats.size() - 1].last = 1'b1;
      end
      foreach (step_beats[i]) begin
         expected_beats.push_back(step_beats[i]);
      end
   endfunction

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   // Compare one output beat against the oldest expectation
   function automatic void check_output_beat();
      out_beat_t want;
      if (expected_beats.size() == 0) begin
         fail_count++;
         $error("unexpected output beat: kind %0d char %0d count %0d",
                rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8]);
      end else begin
         want = expected_beats.pop_front();
         compare_field("kind", 16'(want.kind), 16'(rsp_tuser));
         compare_field("out_char", 16'(want.out_char), 16'(rsp_tdata[7:0]));
         compare_field("total_chars", want.total, rsp_tdata[23:8]);
         compare_field("last", 16'(want.last), 16'(rsp_tlast));
      end
   endfunction

   // Sample both channels at the edge; predict before comparing
   always @(posedge clock) begin
      if (reset) begin
         clear_all();
         expected_beats.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_output_beats(req_tuser[0], req_tdata[6:0], req_tdata[38:7]);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_output_beat();
         end
      end
      beats_pending = expected_beats.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the format string formatter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import fsf_pkg::*;

   localparam logic [6:0] CH_DEL      = 7'h7F;
   localparam int         RANDOM_GOAL = 330;
   localparam int         LONG_HOLD   = 600;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;    // fmt_char [6:0], arg_value [38:7], zero [39]
   logic [0:0]  req_tuser  = '0;    // func [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // out_char [7:0], total_chars [23:8]
   logic [1:0]  rsp_tuser;          // kind [1:0]
   logic        rsp_tlast;

   int fail_count;
   int beats_pending;
   int burst_left    = 0;
   int stim_beats    = 0;
   int hold_requests = 0;

   always #5 clock = ~clock;

   format_string_formatter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   format_string_checker output_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .beats_pending (beats_pending)
   );

   // Receiver: a long hold-off on request, otherwise a changing ready style
   int hold_seen   = 0;
   int hold_left   = 0;
   int ready_style = 0;
   int style_left  = 0;
   int ready_phase = 0;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_seen != hold_requests) begin
         hold_seen  <= hold_requests;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            ready_style <= $urandom_range(0, 3);
            style_left  <= $urandom_range(20, 200);
         end else begin
            style_left <= style_left - 1;
         end
         ready_phase <= ready_phase + 1;
         case (ready_style)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= (ready_phase % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // Offer one beat and hold it until accepted; open a gap when a burst runs out
   task automatic send_beat(input logic func, input logic [6:0] ch, input logic [31:0] arg);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, arg, ch};
      req_tuser  <= func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic put_char(input logic [6:0] ch);
      send_beat(1'b0, ch, $urandom);
      stim_beats++;
   endtask

   task automatic put_arg(input logic [31:0] v);
      send_beat(1'b1, 7'($urandom), v);
      stim_beats++;
   endtask

   // Drop valid and hold off until every predicted beat has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (beats_pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic is_spec_char(logic [6:0] c);
      return c == CH_PERCENT || c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE) ||
             c == CH_LC_D || c == CH_LC_U || c == CH_LC_B || c == CH_LC_O ||
             c == CH_LC_X || c == CH_UC_X || c == CH_LC_C;
   endfunction

   function automatic logic [6:0] pick_unknown_letter();
      logic [6:0] c;
      do c = 7'($urandom_range(1, 127));
      while (is_spec_char(c));
      return c;
   endfunction

   function automatic logic [6:0] pick_conv_letter();
      logic [6:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2: c = CH_LC_D;
         3:       c = CH_LC_U;
         4:       c = CH_LC_B;
         5:       c = CH_LC_O;
         6:       c = CH_LC_X;
         7:       c = CH_UC_X;
         default: c = CH_LC_C;
      endcase
      return c;
   endfunction

   // Bias arguments toward the extremes and toward short numbers
   function automatic logic [31:0] pick_arg();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = 32'h8000_0000;
         1:       v = 32'h7FFF_FFFF;
         2:       v = 32'hFFFF_FFFF;
         3:       v = '0;
         4, 5:    v = $urandom_range(0, 999);
         6:       v = 32'(-int'($urandom_range(1, 999)));
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Well-formed conversion: flags, width, letter, argument
   task automatic send_conversion();
      int ndig;
      put_char(CH_PERCENT);
      if ($urandom_range(0, 3) == 0) put_char(CH_MINUS);
      if ($urandom_range(0, 2) == 0) put_char(CH_ZERO);
      ndig = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(0, 2);
      repeat (ndig) put_char(CH_ZERO + 7'($urandom_range(0, 9)));
      if ($urandom_range(0, 9) == 0) put_char(CH_MINUS);
      put_char(pick_conv_letter());
      put_arg(pick_arg());
   endtask

   task automatic send_text();
      logic [6:0] c;
      repeat ($urandom_range(1, 6)) begin
         do c = 7'($urandom_range(1, 127));
         while (c == CH_PERCENT);
         put_char(c);
      end
   endtask

   // Broken specification, some ignored beats, then the terminator
   task automatic send_broken_spec();
      logic err_mode;
      err_mode = 1'b0;
      put_char(CH_PERCENT);
      case ($urandom_range(0, 3))
         0: begin
            if ($urandom_range(0, 1) == 1) put_char(CH_ZERO + 7'($urandom_range(1, 9)));
            put_char(pick_unknown_letter());
            err_mode = 1'b1;
         end
         1: begin
            put_char(pick_conv_letter());
            put_char(7'($urandom_range(1, 127)));
            err_mode = 1'b1;
         end
         2: put_char(pick_conv_letter());
         default: ;
      endcase
      if (err_mode) begin
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1) == 1) send_beat(1'b1, 7'($urandom), $urandom);
            else send_beat(1'b0, 7'($urandom_range(1, 127)), $urandom);
         end
      end
      put_char(CH_NUL);
   endtask

   // Stimulus: directed, random, then the verdict
   initial begin
      int goal;
      int pick;
      bit second_hold;
      second_hold = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: percent escape, top character, stray argument
      put_char(CH_PERCENT);
      put_char(CH_PERCENT);
      put_char(CH_DEL);
      put_arg(32'hFFFF_FFFF);
      // zero fill with a negative value
      put_char(CH_PERCENT);
      put_char(CH_ZERO);
      put_char(CH_ZERO + 7'd5);
      put_char(CH_LC_D);
      put_arg(32'(-42));
      // left pad, width saturating at the cap, most negative value
      put_char(CH_PERCENT);
      put_char(CH_MINUS);
      put_char(CH_NINE);
      put_char(CH_NINE);
      put_char(CH_LC_D);
      put_arg(32'h8000_0000);
      // zero after a digit is width only; trailing pad and hash
      put_char(CH_PERCENT);
      put_char(CH_ZERO + 7'd3);
      put_char(CH_ZERO);
      put_char(CH_LC_D);
      put_arg(32'd7);
      // character where an argument belongs, ignored beat, terminator
      put_char(CH_PERCENT);
      put_char(CH_UC_X);
      put_char(CH_LC_U);
      put_char(CH_LC_X);
      put_char(CH_NUL);
      wait_drained();

      // random sequences, mostly well formed
      hold_requests <= hold_requests + 1;
      goal = stim_beats + RANDOM_GOAL;
      while (stim_beats < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) send_conversion();
         else if (pick < 70) send_text();
         else if (pick < 76) begin
            put_char(CH_PERCENT);
            put_char(CH_PERCENT);
         end else if (pick < 86) put_char(CH_NUL);
         else if (pick < 94) send_broken_spec();
         else send_beat(1'b1, 7'($urandom), $urandom);
         if ($urandom_range(0, 29) == 0) wait_drained();
         if (!second_hold && stim_beats > goal - RANDOM_GOAL / 2) begin
            hold_requests <= hold_requests + 1;
            second_hold = 1'b1;
         end
      end
      put_char(CH_NUL);

      wait_drained();
      repeat (300) @(posedge clock);
      if (beats_pending != 0) begin
         $error("%0d expected output beats never arrived", beats_pending);
      end
      if (fail_count == 0 && beats_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fsf_pkg.sv
rtl/fsf_front.sv
rtl/fsf_queue.sv
rtl/fsf_back.sv
rtl/format_string_formatter.sv
tb/format_string_checker.sv
tb/testbench.sv
